// File: rtl/rpte_pkg.sv
// Shared types and constants for the radix page table enumerator.
package rpte_pkg;

    localparam int PHYS_W       = 52;
    localparam int VIRT_W       = 48;
    localparam int ENTRY_W      = 64;
    localparam int SIZE_W       = 2;
    localparam int IDX_W        = 9;
    localparam int PAGE_SHIFT   = 12;
    localparam int TBASE_W      = PHYS_W - PAGE_SHIFT;
    localparam int ENTRY_VALID_BIT = 0;
    localparam int ENTRY_HUGE_BIT  = 7;
    localparam int MAX_SIZE_CLASS  = 3;
    localparam logic [IDX_W-1:0] IDX_MAX = 9'd511;

    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 104;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_ENTRY = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        KIND_READ  = 3'd0,
        KIND_LEAF  = 3'd1,
        KIND_TABLE = 3'd2,
        KIND_DONE  = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [PHYS_W-1:0]  phys_addr;
        logic [VIRT_W-1:0]  virt_base;
        logic [SIZE_W-1:0]  size_class;
        logic               last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t res1;
        result_t res0;
    } job_t;

endpackage

// File: rtl/rpte_front.sv
// Walk front end: level stack, entry classification, one or two results per input word.
module rpte_front #(
    parameter int LEVELS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          action,
    input  logic [rpte_pkg::PHYS_W-1:0]   root_addr,
    input  logic [rpte_pkg::ENTRY_W-1:0]  entry_word,
    output rpte_pkg::job_t                job
);
    localparam int LVL_W = $clog2(LEVELS + 1);
    localparam int LIX_W = $clog2(LEVELS);
    localparam int VPN_W = rpte_pkg::IDX_W * LEVELS;
    localparam int TB_W  = rpte_pkg::TBASE_W;
    localparam int IX_W  = rpte_pkg::IDX_W;

    logic [TB_W-1:0]  base_reg [LEVELS];
    logic [TB_W-1:0]  base_next [LEVELS];
    logic [IX_W-1:0]  idx_reg  [LEVELS];
    logic [IX_W-1:0]  idx_next [LEVELS];
    logic [VPN_W-1:0] va_reg   [LEVELS];
    logic [VPN_W-1:0] va_next  [LEVELS];
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             walking_reg, walking_next;

    logic [LIX_W-1:0] lix, sel;
    logic             found;
    logic [TB_W-1:0]  cur_base, adv_base;
    logic [IX_W-1:0]  cur_idx, adv_idx;
    logic [VPN_W-1:0] cur_va, va_add, va;
    logic [rpte_pkg::PHYS_W-1:0] target, cur_addr;
    rpte_pkg::result_t adv_res, zero_res;
    logic             is_leaf;

    always_comb begin
        for (int j = 0; j < LEVELS; j++) begin
            base_next[j] = base_reg[j];
            idx_next[j]  = idx_reg[j];
            va_next[j]   = va_reg[j];
        end
        lvl_next     = lvl_reg;
        walking_next = walking_reg;
        lix          = LIX_W'(lvl_reg - LVL_W'(1));

        cur_base = '0;
        cur_idx  = '0;
        cur_va   = '0;
        va_add   = '0;
        for (int j = 0; j < LEVELS; j++) begin
            if (LIX_W'(j) == lix) begin
                cur_base = base_reg[j];
                cur_idx  = idx_reg[j];
                cur_va   = va_reg[j];
                va_add   = VPN_W'(idx_reg[j]) << (IX_W * j);
            end
        end
        va       = cur_va + va_add;
        target   = {entry_word[rpte_pkg::PHYS_W-1:rpte_pkg::PAGE_SHIFT],
                    rpte_pkg::PAGE_SHIFT'(0)};
        cur_addr = {cur_base, cur_idx, 3'b000};
        is_leaf  = (lix == '0) || entry_word[rpte_pkg::ENTRY_HUGE_BIT];

        // first level at or above the current one whose index has room
        found = 1'b0;
        sel   = '0;
        for (int j = 0; j < LEVELS; j++) begin
            if (!found && LIX_W'(j) >= lix && idx_reg[j] != rpte_pkg::IDX_MAX) begin
                found = 1'b1;
                sel   = LIX_W'(j);
            end
        end
        adv_base = '0;
        adv_idx  = '0;
        for (int j = 0; j < LEVELS; j++) begin
            if (LIX_W'(j) == sel) begin
                adv_base = base_reg[j];
                adv_idx  = idx_reg[j] + IX_W'(1);
            end
        end

        zero_res = '{kind: rpte_pkg::KIND_READ, phys_addr: '0, virt_base: '0,
                     size_class: '0, last: 1'b0};
        adv_res      = zero_res;
        adv_res.last = 1'b1;
        if (found) begin
            adv_res.kind      = rpte_pkg::KIND_READ;
            adv_res.phys_addr = {adv_base, adv_idx, 3'b000};
        end else begin
            adv_res.kind = rpte_pkg::KIND_DONE;
        end

        job      = '{two: 1'b0, res1: zero_res, res0: zero_res};
        job.res0.last = 1'b1;

        if (accept) begin
            if (action == rpte_pkg::ACT_START) begin
                for (int j = 0; j < LEVELS; j++) begin
                    base_next[j] = '0;
                    idx_next[j]  = '0;
                    va_next[j]   = '0;
                end
                base_next[LEVELS-1] = root_addr[rpte_pkg::PHYS_W-1:rpte_pkg::PAGE_SHIFT];
                lvl_next     = LVL_W'(LEVELS);
                walking_next = 1'b1;
                job.res0.kind      = rpte_pkg::KIND_READ;
                job.res0.phys_addr = {root_addr[rpte_pkg::PHYS_W-1:rpte_pkg::PAGE_SHIFT],
                                      rpte_pkg::PAGE_SHIFT'(0)};
            end else if (!walking_reg) begin
                job.res0.kind = rpte_pkg::KIND_ERROR;
            end else if (!entry_word[rpte_pkg::ENTRY_VALID_BIT] || is_leaf) begin
                if (!entry_word[rpte_pkg::ENTRY_VALID_BIT]) begin
                    job.res0 = adv_res;
                end else begin
                    job.two       = 1'b1;
                    job.res1      = adv_res;
                    job.res0.last = 1'b0;
                    if (int'(lix) > rpte_pkg::MAX_SIZE_CLASS) begin
                        job.res0.kind      = rpte_pkg::KIND_ERROR;
                        job.res0.phys_addr = cur_addr;
                    end else begin
                        job.res0.kind       = rpte_pkg::KIND_LEAF;
                        job.res0.phys_addr  = target;
                        job.res0.virt_base  = rpte_pkg::VIRT_W'({va, rpte_pkg::PAGE_SHIFT'(0)});
                        job.res0.size_class = rpte_pkg::SIZE_W'(lix);
                    end
                end
                // step past the entry, popping finished tables
                for (int j = 0; j < LEVELS; j++) begin
                    if (LIX_W'(j) >= lix && (!found || LIX_W'(j) < sel)) begin
                        idx_next[j] = '0;
                    end else if (found && LIX_W'(j) == sel) begin
                        idx_next[j] = adv_idx;
                    end
                end
                lvl_next     = found ? (LVL_W'(sel) + LVL_W'(1)) : '0;
                walking_next = found;
            end else begin
                job.two            = 1'b1;
                job.res0.kind      = rpte_pkg::KIND_TABLE;
                job.res0.phys_addr = target;
                job.res0.last      = 1'b0;
                job.res1.kind      = rpte_pkg::KIND_READ;
                job.res1.phys_addr = target;
                job.res1.last      = 1'b1;
                for (int j = 0; j < LEVELS; j++) begin
                    if (LIX_W'(j) == lix - LIX_W'(1)) begin
                        base_next[j] = target[rpte_pkg::PHYS_W-1:rpte_pkg::PAGE_SHIFT];
                        idx_next[j]  = '0;
                        va_next[j]   = va;
                    end
                end
                lvl_next = lvl_reg - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < LEVELS; j++) begin
                base_reg[j] <= '0;
                idx_reg[j]  <= '0;
                va_reg[j]   <= '0;
            end
            lvl_reg     <= '0;
            walking_reg <= 1'b0;
        end else begin
            for (int j = 0; j < LEVELS; j++) begin
                base_reg[j] <= base_next[j];
                idx_reg[j]  <= idx_next[j];
                va_reg[j]   <= va_next[j];
            end
            lvl_reg     <= lvl_next;
            walking_reg <= walking_next;
        end
    end

endmodule

// File: rtl/rpte_fifo.sv
// Two-entry job queue between the walk front end and the result emitter.
module rpte_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rpte_pkg::job_t push_job,
    input  logic           pop,
    output rpte_pkg::job_t head,
    output logic           full,
    output logic           not_empty
);
    rpte_pkg::job_t                    mem_reg [rpte_pkg::QUEUE_DEPTH];
    logic [rpte_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rpte_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rpte_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                              do_push, do_pop;

    assign full      = (count_reg == rpte_pkg::QUEUE_CNT_W'(rpte_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + rpte_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + rpte_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + rpte_pkg::QUEUE_CNT_W'(do_push)
                                - rpte_pkg::QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/rpte_back.sv
// Result emitter: serializes each queued job into one or two output words.
module rpte_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpte_pkg::job_t    head,
    input  logic              not_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output rpte_pkg::result_t out_res
);
    logic              valid_reg, valid_next;
    logic              phase_reg, phase_next;
    rpte_pkg::result_t res_reg, res_next;
    logic              load;

    always_comb begin
        load       = not_empty && (!valid_reg || out_ready);
        pop        = load && (phase_reg || !head.two);
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        phase_next = load ? (!phase_reg && head.two) : phase_reg;
        res_next   = res_reg;
        if (load) begin
            res_next = phase_reg ? head.res1 : head.res0;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: rtl/radix_page_table_enumerator.sv
// Top level of the radix page table enumerator: front end, job queue, emitter.
//
//  channel  dir  tdata (low bit up)                        tuser        tlast
//  s_       in   root_addr[51:0], entry_word[115:52]       action[0]    -
//  m_       out  phys_addr[51:0], virt_base[99:52],        kind[2:0]    last
//                size_class[101:100]
//
// One input word per cycle, while the job queue has room, when each word gives
// one result; a word that gives two results (leaf, table page) holds the
// output for both words, so the output port sets the rate. Table pops finish
// within the same cycle. Reset clears the level stack. s_tready is low during
// reset and drops otherwise only when the two-entry job queue is full; m_tready
// stalls only the emitter.
module radix_page_table_enumerator #(
    parameter int LEVELS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rpte_pkg::S_DATA_W-1:0]   s_tdata,   // root_addr, entry_word
    input  logic [0:0]                      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpte_pkg::M_DATA_W-1:0]   m_tdata,   // phys_addr, virt_base, size_class
    output logic [2:0]                      m_tuser,   // kind
    output logic                            m_tlast
);
    rpte_pkg::job_t    push_job, head_job;
    rpte_pkg::result_t out_res;
    logic              accept, q_full, q_not_empty, q_pop;

    assign s_tready = aresetn && !q_full;
    assign accept   = s_tvalid && s_tready;

    rpte_front #(.LEVELS(LEVELS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .action     (s_tuser[0]),
        .root_addr  (s_tdata[rpte_pkg::PHYS_W-1:0]),
        .entry_word (s_tdata[rpte_pkg::PHYS_W+rpte_pkg::ENTRY_W-1:rpte_pkg::PHYS_W]),
        .job        (push_job)
    );

    rpte_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_job  (push_job),
        .pop       (q_pop),
        .head      (head_job),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    rpte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head_job),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res.size_class, out_res.virt_base, out_res.phys_addr};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// File: rtl/rpte_checker.sv
// Port-level checks on the enumerator's result channel, bound to the top level.
module rpte_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rpte_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [2:0]                     m_tuser,
    input logic                           m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_pair_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rpte_pkg::KIND_LEAF || m_tuser == rpte_pkg::KIND_TABLE)
        |-> !m_tlast)
        else $error("leaf or table word marked last");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rpte_pkg::KIND_READ || m_tuser == rpte_pkg::KIND_DONE)
        |-> m_tlast)
        else $error("read request or done word not marked last");

    a_nonleaf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != rpte_pkg::KIND_LEAF |-> m_tdata[101:52] == '0)
        else $error("virtual base or size set on a non-leaf word");

    a_read_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rpte_pkg::KIND_READ |-> m_tdata[2:0] == 3'b000)
        else $error("read request not entry aligned");

endmodule

bind radix_page_table_enumerator rpte_checker u_rpte_checker (.*);
